@@ hdl/ilist_pkg.sv @@
// Shared types and constants for the index linked list block.
// No dependencies; imported by ilist_node_mem, ilist_ctrl and the top level.
package ilist_pkg;

  localparam int NODES     = 4096;
  localparam int IDX_BITS  = $clog2(NODES);
  localparam int LINK_BITS = IDX_BITS + 1;   // signed index, all ones = null
  localparam int CNT_BITS  = IDX_BITS + 1;   // holds 0..NODES
  localparam int WORD_BITS = 56;

  localparam logic [LINK_BITS-1:0] NULL_LINK = '1;
  localparam logic [CNT_BITS-1:0]  CNT_FULL  = CNT_BITS'(NODES);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NO_SUCC = 2'd2,
    STAT_UNALLOC = 2'd3
  } status_t;

  // One shared read address for both arrays, separate write ports.
  typedef struct packed {
    logic                 rd_en;
    logic [IDX_BITS-1:0]  rd_addr;
    logic                 lk_we;
    logic [IDX_BITS-1:0]  lk_waddr;
    logic [LINK_BITS-1:0] lk_wdata;
    logic                 wd_we;
    logic [IDX_BITS-1:0]  wd_waddr;
    logic [WORD_BITS-1:0] wd_wdata;
  } mem_req_t;

endpackage

@@ hdl/index_linked_list_insert_delete_top.sv @@
// Index linked list block: array-backed singly linked list with
// insert-after / delete-after commands.
// Usage:
//   Input: drive in_opcode (0 insert after, 1 delete after), in_after_index
//   (node to act after, -1 for the front) and in_word_in, raise start. The
//   command is taken at a clock edge where start is high and busy is low.
//   Output: exactly one result word per command, shown for one cycle with
//   out_strobe high: out_status (0 ok, 1 full, 2 no successor, 3 index not
//   allocated), out_new_index on an ok insert, out_word_out on an ok delete;
//   unused fields read zero.
// Timing: one command at a time. Errors and front inserts finish on
//   acceptance; a front delete adds a victim read; insert or delete after a
//   node runs link read, victim read or new node write, link patch (a delete
//   with no successor ends at the link read). The result appears the cycle
//   after the command finishes, and busy drops with it, so a new command can
//   overlap the strobe. The node memory's single read port sets the steps.
// Reset (rst_n low, synchronous): empty list, allocation count zero. The node
//   memory is not cleared; only allocated entries are ever read.
// The receiver cannot stall: each result must be taken in its strobe cycle.
// Depends on ilist_pkg, ilist_node_mem, ilist_ctrl.
module index_linked_list_insert_delete_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [ilist_pkg::LINK_BITS-1:0] in_after_index,
  input  logic [ilist_pkg::WORD_BITS-1:0] in_word_in,
  output logic                            out_strobe,
  output logic [1:0]                      out_status,
  output logic [ilist_pkg::IDX_BITS-1:0]  out_new_index,
  output logic [ilist_pkg::WORD_BITS-1:0] out_word_out
);
  import ilist_pkg::*;

  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] word_rd;
  logic [LINK_BITS-1:0] link_rd;

  ilist_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_after_index (in_after_index),
    .in_word_in     (in_word_in),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_new_index  (out_new_index),
    .out_word_out   (out_word_out),
    .mem_req        (mem_req),
    .word_rd        (word_rd),
    .link_rd        (link_rd)
  );

  ilist_node_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .word_rd (word_rd),
    .link_rd (link_rd)
  );

endmodule

@@ hdl/ilist_node_mem.sv @@
// Node storage: word array and next-link array, synchronous read.
// Depends on ilist_pkg.
module ilist_node_mem (
  input  logic                           clk,
  input  ilist_pkg::mem_req_t            req,
  output logic [ilist_pkg::WORD_BITS-1:0] word_rd,
  output logic [ilist_pkg::LINK_BITS-1:0] link_rd
);
  import ilist_pkg::*;

  logic [WORD_BITS-1:0] words [NODES];
  logic [LINK_BITS-1:0] links [NODES];
  logic [WORD_BITS-1:0] word_rd_r;
  logic [LINK_BITS-1:0] link_rd_r;

  always_ff @(posedge clk) begin
    if (req.wd_we) begin
      words[req.wd_waddr] <= req.wd_wdata;
    end
    if (req.rd_en) begin
      word_rd_r <= words[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.lk_we) begin
      links[req.lk_waddr] <= req.lk_wdata;
    end
    if (req.rd_en) begin
      link_rd_r <= links[req.rd_addr];
    end
  end

  assign word_rd = word_rd_r;
  assign link_rd = link_rd_r;

endmodule

@@ hdl/ilist_ctrl.sv @@
// Sequencer for insert-after / delete-after: head pointer, bump allocator,
// read-modify-write of the node memory. Depends on ilist_pkg.
module ilist_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [ilist_pkg::LINK_BITS-1:0] in_after_index,
  input  logic [ilist_pkg::WORD_BITS-1:0] in_word_in,
  output logic                            out_strobe,
  output logic [1:0]                      out_status,
  output logic [ilist_pkg::IDX_BITS-1:0]  out_new_index,
  output logic [ilist_pkg::WORD_BITS-1:0] out_word_out,
  output ilist_pkg::mem_req_t             mem_req,
  input  logic [ilist_pkg::WORD_BITS-1:0] word_rd,
  input  logic [ilist_pkg::LINK_BITS-1:0] link_rd
);
  import ilist_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK_WAIT,  // link of after node on read port
    ST_INS_FIX,    // patch link of after node
    ST_DEL_WAIT    // victim word and link on read port
  } state_t;

  state_t               state_r, state_nxt;
  logic                 op_r, op_nxt;
  logic [LINK_BITS-1:0] after_r, after_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [LINK_BITS-1:0] head_r, head_nxt;
  logic [CNT_BITS-1:0]  alloc_r, alloc_nxt;
  logic                 strobe_r, strobe_nxt;
  status_t              status_r, status_nxt;
  logic [IDX_BITS-1:0]  new_idx_r, new_idx_nxt;
  logic [WORD_BITS-1:0] word_out_r, word_out_nxt;

  logic                 accept;
  logic                 in_front;
  logic                 in_after_ok;
  logic                 front_r;
  logic [IDX_BITS-1:0]  alloc_idx;

  // A link names a live node when it is non-negative and below the count.
  function automatic logic link_ok(input logic [LINK_BITS-1:0] lk,
                                   input logic [CNT_BITS-1:0]  cnt);
    link_ok = !lk[LINK_BITS-1] && (CNT_BITS'(lk[IDX_BITS-1:0]) < cnt);
  endfunction

  assign accept      = start && !busy;
  assign in_front    = (in_after_index == NULL_LINK);
  assign in_after_ok = in_front || link_ok(in_after_index, alloc_r);
  assign front_r     = (after_r == NULL_LINK);
  assign alloc_idx   = alloc_r[IDX_BITS-1:0];

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    after_nxt    = after_r;
    word_nxt     = word_r;
    head_nxt     = head_r;
    alloc_nxt    = alloc_r;
    strobe_nxt   = 1'b0;
    status_nxt   = STAT_OK;
    new_idx_nxt  = '0;
    word_out_nxt = '0;
    mem_req      = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_opcode;
          after_nxt = in_after_index;
          word_nxt  = in_word_in;
          if (!in_after_ok) begin
            strobe_nxt = 1'b1;
            status_nxt = STAT_UNALLOC;
          end else if (in_opcode == OP_INSERT) begin
            if (alloc_r == CNT_FULL) begin
              strobe_nxt = 1'b1;
              status_nxt = STAT_FULL;
            end else if (in_front) begin
              mem_req.wd_we    = 1'b1;
              mem_req.wd_waddr = alloc_idx;
              mem_req.wd_wdata = in_word_in;
              mem_req.lk_we    = 1'b1;
              mem_req.lk_waddr = alloc_idx;
              mem_req.lk_wdata = head_r;
              head_nxt         = {1'b0, alloc_idx};
              alloc_nxt        = alloc_r + 1'b1;
              strobe_nxt       = 1'b1;
              new_idx_nxt      = alloc_idx;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = in_after_index[IDX_BITS-1:0];
              state_nxt       = ST_LINK_WAIT;
            end
          end else if (in_front) begin
            if (!link_ok(head_r, alloc_r)) begin
              strobe_nxt = 1'b1;
              status_nxt = STAT_NO_SUCC;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = head_r[IDX_BITS-1:0];
              state_nxt       = ST_DEL_WAIT;
            end
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = in_after_index[IDX_BITS-1:0];
            state_nxt       = ST_LINK_WAIT;
          end
        end
      end

      ST_LINK_WAIT: begin
        if (op_r == OP_INSERT) begin
          mem_req.wd_we    = 1'b1;
          mem_req.wd_waddr = alloc_idx;
          mem_req.wd_wdata = word_r;
          mem_req.lk_we    = 1'b1;
          mem_req.lk_waddr = alloc_idx;
          mem_req.lk_wdata = link_rd;
          state_nxt        = ST_INS_FIX;
        end else if (!link_ok(link_rd, alloc_r)) begin
          strobe_nxt = 1'b1;
          status_nxt = STAT_NO_SUCC;
          state_nxt  = ST_IDLE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = link_rd[IDX_BITS-1:0];
          state_nxt       = ST_DEL_WAIT;
        end
      end

      ST_INS_FIX: begin
        mem_req.lk_we    = 1'b1;
        mem_req.lk_waddr = after_r[IDX_BITS-1:0];
        mem_req.lk_wdata = {1'b0, alloc_idx};
        alloc_nxt        = alloc_r + 1'b1;
        strobe_nxt       = 1'b1;
        new_idx_nxt      = alloc_idx;
        state_nxt        = ST_IDLE;
      end

      ST_DEL_WAIT: begin
        if (front_r) begin
          head_nxt = link_rd;
        end else begin
          mem_req.lk_we    = 1'b1;
          mem_req.lk_waddr = after_r[IDX_BITS-1:0];
          mem_req.lk_wdata = link_rd;
        end
        strobe_nxt   = 1'b1;
        word_out_nxt = word_rd;
        state_nxt    = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= NULL_LINK;
      alloc_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      alloc_r  <= alloc_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r       <= op_nxt;
    after_r    <= after_nxt;
    word_r     <= word_nxt;
    status_r   <= status_nxt;
    new_idx_r  <= new_idx_nxt;
    word_out_r <= word_out_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_strobe    = strobe_r;
  assign out_status    = status_r;
  assign out_new_index = new_idx_r;
  assign out_word_out  = word_out_r;

endmodule

@@ bench/index_linked_list_insert_delete_top_tb.sv @@
// Self-checking bench for index_linked_list_insert_delete_top: inserts and deletes on the
// array-backed list, checked against a shadow copy of the list kept in the bench.
// Depends on ilist_pkg and the RTL under hdl/.
module index_linked_list_insert_delete_top_tb;
  import ilist_pkg::*;

  localparam int STALL_LIMIT = 200;

  typedef struct {
    status_t              status;
    logic [IDX_BITS-1:0]  new_index;
    logic [WORD_BITS-1:0] word_out;
  } list_reply_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic                 in_opcode      = OP_INSERT;
  logic [LINK_BITS-1:0] in_after_index = NULL_LINK;
  logic [WORD_BITS-1:0] in_word_in     = '0;
  logic                 out_strobe;
  logic [1:0]           out_status;
  logic [IDX_BITS-1:0]  out_new_index;
  logic [WORD_BITS-1:0] out_word_out;

  index_linked_list_insert_delete_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_after_index (in_after_index),
    .in_word_in     (in_word_in),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_new_index  (out_new_index),
    .out_word_out   (out_word_out)
  );

  always #5 clk = ~clk;

  // shadow of the node memory and list pointers
  logic [WORD_BITS-1:0] shadow_words [NODES];
  logic [LINK_BITS-1:0] shadow_links [NODES];
  bit                   shadow_live  [NODES];
  logic [LINK_BITS-1:0] shadow_head  = NULL_LINK;
  logic [CNT_BITS-1:0]  shadow_count = '0;

  list_reply_t awaited_replies[$];
  int          errors  = 0;
  bit          no_gaps = 1'b0;

  function automatic list_reply_t list_update(input logic op,
                                              input logic [LINK_BITS-1:0] after,
                                              input logic [WORD_BITS-1:0] word);
    list_reply_t          r;
    logic [IDX_BITS-1:0]  n;
    logic [LINK_BITS-1:0] victim;
    r.status    = STAT_OK;
    r.new_index = '0;
    r.word_out  = '0;
    if (after != NULL_LINK && (after[LINK_BITS-1] || after >= shadow_count)) begin
      r.status = STAT_UNALLOC;
    end else if (op == OP_INSERT) begin
      if (shadow_count == CNT_FULL) begin
        r.status = STAT_FULL;
      end else begin
        n = shadow_count[IDX_BITS-1:0];
        shadow_words[n] = word;
        shadow_live[n]  = 1'b1;
        if (after == NULL_LINK) begin
          shadow_links[n] = shadow_head;
          shadow_head     = {1'b0, n};
        end else begin
          shadow_links[n] = shadow_links[after[IDX_BITS-1:0]];
          shadow_links[after[IDX_BITS-1:0]] = {1'b0, n};
        end
        shadow_count = shadow_count + 1'b1;
        r.new_index  = n;
      end
    end else begin
      victim = (after == NULL_LINK) ? shadow_head : shadow_links[after[IDX_BITS-1:0]];
      if (victim[LINK_BITS-1] || victim >= shadow_count) begin
        r.status = STAT_NO_SUCC;
      end else begin
        r.word_out = shadow_words[victim[IDX_BITS-1:0]];
        shadow_live[victim[IDX_BITS-1:0]] = 1'b0;
        if (after == NULL_LINK)
          shadow_head = shadow_links[victim[IDX_BITS-1:0]];
        else
          shadow_links[after[IDX_BITS-1:0]] = shadow_links[victim[IDX_BITS-1:0]];
      end
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[WORD_BITS-1:0];
  endfunction

  // Mostly a node still in the list, sometimes the front, sometimes junk.
  function automatic logic [LINK_BITS-1:0] pick_anchor();
    int          roll;
    int unsigned idx;
    roll = $urandom_range(0, 99);
    idx  = 0;
    if (roll < 15 || shadow_count == 0)
      return NULL_LINK;
    if (roll < 23) begin
      if ($urandom_range(0, 1))
        return LINK_BITS'($urandom);
      return LINK_BITS'(shadow_count) + LINK_BITS'($urandom_range(0, 3));
    end
    for (int t = 0; t < 8; t++) begin
      idx = $urandom_range(0, shadow_count - 1);
      if (shadow_live[idx])
        break;
    end
    return LINK_BITS'(idx);
  endfunction

  // start stays high across back-to-back commands; dropped only for a gap
  task automatic send_cmd(input logic op, input logic [LINK_BITS-1:0] after,
                          input logic [WORD_BITS-1:0] word);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode      <= op;
    in_after_index <= after;
    in_word_in     <= word;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    awaited_replies.push_back(list_update(op, after, word));
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  task automatic test_empty_list();
    send_cmd(OP_DELETE, NULL_LINK, '1);
    send_cmd(OP_INSERT, LINK_BITS'(0), '1);
    send_cmd(OP_DELETE, LINK_BITS'(0), '0);
    send_cmd(OP_INSERT, LINK_BITS'(-2), rand_word());
    send_cmd(OP_DELETE, LINK_BITS'(-NODES), rand_word());
    send_cmd(OP_INSERT, LINK_BITS'(NODES - 1), rand_word());
  endtask

  task automatic test_basic_ops();
    send_cmd(OP_INSERT, NULL_LINK, '1);
    send_cmd(OP_INSERT, NULL_LINK, '0);
    send_cmd(OP_INSERT, LINK_BITS'(0), 56'hA5_5A5A_A5A5_5A5A);
    send_cmd(OP_INSERT, LINK_BITS'(2), 56'h5A_A5A5_5A5A_A5A5);
    send_cmd(OP_DELETE, LINK_BITS'(3), '0);            // tail
    send_cmd(OP_DELETE, LINK_BITS'(1), '0);
    send_cmd(OP_DELETE, NULL_LINK, '0);
    // acting after freed nodes follows their stale links
    send_cmd(OP_DELETE, LINK_BITS'(0), '0);
    send_cmd(OP_INSERT, LINK_BITS'(1), rand_word());
    send_cmd(OP_INSERT, LINK_BITS'(shadow_count), rand_word());
    send_cmd(OP_DELETE, LINK_BITS'(shadow_count), rand_word());
    send_cmd(OP_INSERT, NULL_LINK, rand_word());
    send_cmd(OP_DELETE, NULL_LINK, rand_word());
  endtask

  task automatic test_random_mix(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0)
        no_gaps = ($urandom_range(0, 3) == 0);
      send_cmd(($urandom_range(0, 99) < 55) ? OP_INSERT : OP_DELETE, pick_anchor(),
               rand_word());
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (rst_n && out_strobe) begin
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: status %0d index %0d word %h", $time,
                 out_status, out_new_index, out_word_out);
      end else begin
        want = awaited_replies.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_new_index !== want.new_index) begin
          errors++;
          $display("%0t: new_index expected %0d actual %0d", $time, want.new_index,
                   out_new_index);
        end
        if (out_word_out !== want.word_out) begin
          errors++;
          $display("%0t: word_out expected %h actual %h", $time, want.word_out,
                   out_word_out);
        end
      end
    end
  end

  initial begin : stall_watch
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe)
        idle = 0;
      else
        idle++;
    end
    $display("index_linked_list_insert_delete_top regression: fail");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_basic_ops();
    drain_replies();
    test_random_mix(1530);
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("index_linked_list_insert_delete_top regression: pass");
    else
      $display("index_linked_list_insert_delete_top regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ilist_pkg.sv
hdl/ilist_node_mem.sv
hdl/ilist_ctrl.sv
hdl/index_linked_list_insert_delete_top.sv
bench/index_linked_list_insert_delete_top_tb.sv
